// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SACTE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sacte assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SACTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sacte assertion failed");

// Check on the first edge after reset is released.
`define SACTE_ASSERT_RESET_EXIT(lbl, cons) \
  lbl: assert property (@(posedge clk) $rose(rst_n) |-> (cons)) \
    else $error("sacte assertion failed");

`endif

// ===== rtl/sacte_pkg.sv =====
// ----------------------------------------------------------------------------
// Cache tag engine package
// Sizes, codes, row layout and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
package sacte_pkg;

  localparam int MAX_SETS   = 1024;
  localparam int MAX_WAYS   = 8;
  localparam int ADDR_W     = 32;
  localparam int SET_W      = $clog2(MAX_SETS);
  localparam int SIDX_W     = SET_W + 1;
  localparam int NUM_SETS   = 2 * MAX_SETS;
  localparam int WAY_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W     = 4;
  localparam int BL_MIN     = 4;
  localparam int BL_MAX     = 8;
  localparam int TAG_W      = ADDR_W - BL_MIN;
  localparam int STAMP_W    = 32;
  localparam int CTR_W      = 32;
  localparam int NUM_CTR    = 6;
  localparam int LFSR_W     = 16;
  localparam int RCNT_W     = $clog2(LFSR_W + 1);
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int OUT_SET_W  = 10;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PSETS    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ISETS    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PREFETCH = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WALLOC   = 4'd7;

  // Request kinds.
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_FETCH = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // Replacement policies.
  localparam logic [1:0] POL_LRU  = 2'd0;
  localparam logic [1:0] POL_FIFO = 2'd1;
  localparam logic [1:0] POL_RAND = 2'd2;

  // One set of the tag store: all ways plus the fill count.
  typedef struct packed {
    logic [MAX_WAYS-1:0]              valid;
    logic [MAX_WAYS-1:0][TAG_W-1:0]   tag;
    logic [MAX_WAYS-1:0][STAMP_W-1:0] used;
    logic [MAX_WAYS-1:0][STAMP_W-1:0] filled;
    logic [WCNT_W-1:0]                cnt;
  } row_t;

  typedef struct packed {
    logic clr;
    logic accept;
    logic rd;
    logic look;
    logic write_hit;
    logic fill_empty;
    logic vscan_init;
    logic vscan_step;
    logic vrand_init;
    logic vrand_step;
    logic vfill;
    logic to_pf;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_bad;
    logic hit;
    logic need_fill;
    logic empty_ok;
    logic pol_rand;
    logic pf_go;
    logic pf_phase;
    logic scan_done;
    logic rand_done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/sacte_intf.sv =====
// ----------------------------------------------------------------------------
// Cache tag engine channels
// Valid/ready interfaces for requests, results and configuration writes.
// ----------------------------------------------------------------------------
interface sacte_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] address;

  modport source (output valid, req_type, address, input ready);
  modport sink (input valid, req_type, address, output ready);
endinterface

interface sacte_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [9:0]  set_index;
  logic [31:0] read_accesses;
  logic [31:0] write_accesses;
  logic [31:0] fetch_accesses;
  logic [31:0] read_misses;
  logic [31:0] write_misses;
  logic [31:0] fetch_misses;

  modport source (output valid, hit, set_index, read_accesses, write_accesses,
                  fetch_accesses, read_misses, write_misses, fetch_misses,
                  input ready);
  modport sink (input valid, hit, set_index, read_accesses, write_accesses,
                fetch_accesses, read_misses, write_misses, fetch_misses,
                output ready);
endinterface

interface sacte_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] reg_index;
  logic [7:0] data;

  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

// ===== rtl/sacte_ctrl.sv =====
// ----------------------------------------------------------------------------
// Cache tag engine controller
// Sequences the clearing pass, lookups, victim selection, fills and prefetch.
// ----------------------------------------------------------------------------
module sacte_ctrl import sacte_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_RD, S_LOOK, S_VSCAN, S_VRAND, S_VFILL, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.in_bad ? S_FIN : S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_LOOK;
      end
      S_LOOK: begin
        cmd.look = 1'b1;
        priority if (sts.hit) begin
          cmd.write_hit = !sts.pf_phase;
          state_nxt     = S_FIN;
        end else if (!sts.need_fill) begin
          state_nxt = S_FIN;
        end else if (sts.empty_ok) begin
          cmd.fill_empty = 1'b1;
          cmd.to_pf      = sts.pf_go;
          state_nxt      = sts.pf_go ? S_RD : S_FIN;
        end else if (sts.pol_rand) begin
          cmd.vrand_init = 1'b1;
          state_nxt      = S_VRAND;
        end else begin
          cmd.vscan_init = 1'b1;
          state_nxt      = S_VSCAN;
        end
      end
      S_VSCAN: begin
        if (sts.scan_done) state_nxt = S_VFILL;
        else cmd.vscan_step = 1'b1;
      end
      S_VRAND: begin
        if (sts.rand_done) state_nxt = S_VFILL;
        else cmd.vrand_step = 1'b1;
      end
      S_VFILL: begin
        cmd.vfill = 1'b1;
        cmd.to_pf = sts.pf_go;
        state_nxt = sts.pf_go ? S_RD : S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/sacte_dpath.sv =====
// ----------------------------------------------------------------------------
// Cache tag engine datapath
// Configuration registers, tag store memory, compare, victim units and counters.
// ----------------------------------------------------------------------------
module sacte_dpath import sacte_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [1:0]            in_req_type,
  input  logic [ADDR_W-1:0]     in_address,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_hit,
  output logic [OUT_SET_W-1:0]  out_set_index,
  output logic [CTR_W-1:0]      out_ctr [NUM_CTR]
);

  // Configuration registers.
  logic       split_r, pf_en_r, walloc_r;
  logic [3:0] bl_cfg_r, ways_cfg_r, psets_r, isets_r;
  logic [1:0] pol_r;

  // Request context.
  logic [1:0]        kind_r;
  logic              cidx_r;
  logic [ADDR_W-1:0] addr_r;
  logic [3:0]        bl_r;
  logic [3:0]        slg_r;
  logic [SET_W-1:0]  set_r;
  logic [SIDX_W-1:0] cur_sidx_r;
  logic [TAG_W-1:0]  cur_blk_r;
  logic              pf_r;
  logic              hit_r;

  // Tag store.
  row_t mem [NUM_SETS];
  row_t row_q;
  row_t wr_row;
  logic              mem_we;
  logic [SIDX_W-1:0] mem_wa;
  row_t              mem_wd;
  logic [SIDX_W-1:0] clr_idx_r;

  // Shared state.
  logic [STAMP_W-1:0] stamp_r;
  logic [CTR_W-1:0]   ctr_r [NUM_CTR];
  logic [LFSR_W-1:0]  lfsr_r;

  // Victim units.
  logic [WAY_W-1:0]   best_r;
  logic [STAMP_W-1:0] best_v_r;
  logic [WCNT_W-1:0]  scan_r;
  logic [WAY_W-1:0]   rem_r;
  logic [RCNT_W-1:0]  rcnt_r;

  // Output register.
  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [OUT_SET_W-1:0] out_set_r;
  logic [CTR_W-1:0]     out_ctr_r [NUM_CTR];

  // Effective configuration.
  logic [WCNT_W-1:0] ways_eff;
  logic [3:0]        bl_eff;
  logic [3:0]        slg_in;
  logic              cidx_in;
  logic [ADDR_W-1:0] blk_full;
  logic [SET_W-1:0]  set_in;

  function automatic logic [SET_W-1:0] set_mask(input logic [3:0] lg);
    logic [SET_W:0] m;
    m = ((SET_W+1)'(1) << lg) - (SET_W+1)'(1);
    return m[SET_W-1:0];
  endfunction

  always_comb begin
    ways_eff = ways_cfg_r;
    if (ways_cfg_r == 4'd0) ways_eff = WCNT_W'(1);
    if (ways_cfg_r > WCNT_W'(MAX_WAYS)) ways_eff = WCNT_W'(MAX_WAYS);
    bl_eff = bl_cfg_r;
    if (bl_cfg_r < 4'(BL_MIN)) bl_eff = 4'(BL_MIN);
    if (bl_cfg_r > 4'(BL_MAX)) bl_eff = 4'(BL_MAX);
    cidx_in = split_r && (in_req_type == REQ_FETCH);
    slg_in  = cidx_in ? isets_r : psets_r;
    if (slg_in > 4'(SET_W)) slg_in = 4'(SET_W);
    blk_full = in_address >> bl_eff;
    set_in   = blk_full[SET_W-1:0] & set_mask(slg_in);
  end

  // Way compare on the row read back from the store.
  logic [MAX_WAYS-1:0] hv, ev;
  logic [WAY_W-1:0]    hit_way, empty_way;
  logic                any_hit, any_empty;

  always_comb begin
    hit_way   = '0;
    empty_way = '0;
    any_hit   = 1'b0;
    any_empty = 1'b0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      hv[w] = (WCNT_W'(w) < ways_eff) && row_q.valid[w] && (row_q.tag[w] == cur_blk_r);
      ev[w] = (WCNT_W'(w) < ways_eff) && !row_q.valid[w];
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hv[w]) begin
        hit_way = WAY_W'(w);
        any_hit = 1'b1;
      end
      if (ev[w]) begin
        empty_way = WAY_W'(w);
        any_empty = 1'b1;
      end
    end
  end

  // Status to the controller.
  always_comb begin
    sts.clr_last  = (clr_idx_r == SIDX_W'(NUM_SETS - 1));
    sts.in_bad    = (in_req_type == REQ_NONE);
    sts.hit       = any_hit;
    sts.need_fill = pf_r || !(kind_r == REQ_WRITE && !walloc_r);
    sts.empty_ok  = any_empty && (row_q.cnt < ways_eff);
    sts.pol_rand  = (pol_r == POL_RAND);
    sts.pf_go     = !pf_r && pf_en_r;
    sts.pf_phase  = pf_r;
    sts.scan_done = (scan_r >= ways_eff);
    sts.rand_done = (rcnt_r == RCNT_W'(LFSR_W));
    sts.out_free  = !out_valid_r || out_ready;
  end

  // Row update for a hit refresh or a fill.
  logic [WAY_W-1:0]   fill_slot;
  logic [STAMP_W-1:0] scan_v;
  logic [WAY_W:0]     rem_t;

  always_comb begin
    fill_slot = cmd.vfill ? ((pol_r == POL_RAND) ? rem_r : best_r) : empty_way;
    wr_row    = row_q;
    if (cmd.write_hit) begin
      wr_row.used[hit_way] = stamp_r;
    end else begin
      wr_row.tag[fill_slot]    = cur_blk_r;
      wr_row.valid[fill_slot]  = 1'b1;
      wr_row.used[fill_slot]   = stamp_r;
      wr_row.filled[fill_slot] = stamp_r;
      if (cmd.fill_empty && row_q.cnt < WCNT_W'(MAX_WAYS)) wr_row.cnt = row_q.cnt + 1'b1;
    end
    mem_we = cmd.clr || cmd.write_hit || cmd.fill_empty || cmd.vfill;
    mem_wa = cmd.clr ? clr_idx_r : cur_sidx_r;
    mem_wd = cmd.clr ? '0 : wr_row;
    scan_v = (pol_r == POL_FIFO) ? row_q.filled[scan_r[WAY_W-1:0]]
                                 : row_q.used[scan_r[WAY_W-1:0]];
    rem_t = {rem_r, lfsr_r[LFSR_W - 1 - int'(rcnt_r[RCNT_W-2:0])]};
    if ({1'b0, rem_t} >= (WAY_W+2)'(ways_eff)) rem_t = rem_t - (WAY_W+1)'(ways_eff);
  end

  // Tag store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.rd) row_q <= mem[cur_sidx_r];
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_r    <= 1'b0;
      bl_cfg_r   <= 4'd4;
      ways_cfg_r <= 4'd1;
      psets_r    <= 4'd6;
      isets_r    <= 4'd6;
      pol_r      <= POL_LRU;
      pf_en_r    <= 1'b0;
      walloc_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SPLIT:    split_r    <= cfg_data[0];
        REG_BLOCK:    bl_cfg_r   <= cfg_data[3:0];
        REG_WAYS:     ways_cfg_r <= cfg_data[3:0];
        REG_PSETS:    psets_r    <= cfg_data[3:0];
        REG_ISETS:    isets_r    <= cfg_data[3:0];
        REG_POLICY:   pol_r      <= cfg_data[1:0];
        REG_PREFETCH: pf_en_r    <= cfg_data[0];
        REG_WALLOC:   walloc_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Control state: clear pointer, stamp, counters, LFSR, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      stamp_r     <= '0;
      lfsr_r      <= LFSR_SEED;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_CTR; k++) ctr_r[k] <= '0;
    end else begin
      if (cmd.clr) clr_idx_r <= clr_idx_r + 1'b1;
      if (cmd.accept && in_req_type != REQ_NONE) begin
        stamp_r <= stamp_r + 1'b1;
        for (int k = 0; k < 3; k++) begin
          if (in_req_type == 2'(k) && ~&ctr_r[k]) ctr_r[k] <= ctr_r[k] + 1'b1;
        end
      end
      if (cmd.look && !pf_r && !any_hit) begin
        for (int k = 0; k < 3; k++) begin
          if (kind_r == 2'(k) && ~&ctr_r[k+3]) ctr_r[k+3] <= ctr_r[k+3] + 1'b1;
        end
      end
      if (cmd.vrand_init) begin
        lfsr_r <= lfsr_r[0] ? ((lfsr_r >> 1) ^ LFSR_TAPS) : (lfsr_r >> 1);
      end
      if (cmd.finish) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Request context, victim units and result payload.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r     <= in_req_type;
      cidx_r     <= cidx_in;
      addr_r     <= in_address;
      bl_r       <= bl_eff;
      slg_r      <= slg_in;
      set_r      <= (in_req_type == REQ_NONE) ? '0 : set_in;
      cur_sidx_r <= {cidx_in, set_in};
      cur_blk_r  <= blk_full[TAG_W-1:0];
      pf_r       <= 1'b0;
      hit_r      <= 1'b0;
    end
    if (cmd.look && !pf_r) hit_r <= any_hit;
    if (cmd.to_pf) begin
      pf_r       <= 1'b1;
      cur_sidx_r <= {cidx_r, (set_r + 1'b1) & set_mask(slg_r)};
      cur_blk_r  <= TAG_W'((addr_r + (ADDR_W'(1) << bl_r)) >> bl_r);
    end
    if (cmd.vscan_init) begin
      best_r   <= '0;
      best_v_r <= (pol_r == POL_FIFO) ? row_q.filled[0] : row_q.used[0];
      scan_r   <= WCNT_W'(1);
    end
    if (cmd.vscan_step) begin
      if (scan_v < best_v_r) begin
        best_r   <= scan_r[WAY_W-1:0];
        best_v_r <= scan_v;
      end
      scan_r <= scan_r + 1'b1;
    end
    if (cmd.vrand_init) begin
      rem_r  <= '0;
      rcnt_r <= '0;
    end
    if (cmd.vrand_step) begin
      rem_r  <= rem_t[WAY_W-1:0];
      rcnt_r <= rcnt_r + 1'b1;
    end
    if (cmd.finish) begin
      out_hit_r <= hit_r;
      out_set_r <= OUT_SET_W'(set_r);
      for (int k = 0; k < NUM_CTR; k++) out_ctr_r[k] <= ctr_r[k];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_set_index = out_set_r;
  assign out_ctr       = out_ctr_r;

endmodule

// ===== rtl/set_assoc_cache_tag_engine.sv =====
// A hit, a plain miss or an empty-way fill is the shortest path; an LRU/FIFO victim scan
// over the ways or a random victim draw from the LFSR adds to it, and a prefetch adds a
// second lookup plus its own victim selection. An unknown kind skips the lookup. One
// request is in flight at a time: a new request is taken only once the last result
// has been handed to the output register. After reset a clearing pass zeroes every
// row of the tag store first; configuration is taken at any time.
// ----------------------------------------------------------------------------
// Set-associative cache tag engine
// Tag lookup, replacement and prefetch for a unified or split cache, with counters.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_engine import sacte_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  sacte_in_if.sink      in_ch,
  sacte_out_if.source   out_ch,
  sacte_cfg_if.sink     cfg_ch
);

  cmd_t             cmd;
  sts_t             sts;
  logic [CTR_W-1:0] ctr [NUM_CTR];

  // Configuration writes are always taken.
  assign cfg_ch.ready = 1'b1;

  sacte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sacte_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_req_type   (in_ch.req_type),
    .in_address    (in_ch.address),
    .cfg_we        (cfg_ch.valid),
    .cfg_idx       (cfg_ch.reg_index),
    .cfg_data      (cfg_ch.data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_hit       (out_ch.hit),
    .out_set_index (out_ch.set_index),
    .out_ctr       (ctr)
  );

  // Counter snapshot onto the result channel.
  assign out_ch.read_accesses  = ctr[0];
  assign out_ch.write_accesses = ctr[1];
  assign out_ch.fetch_accesses = ctr[2];
  assign out_ch.read_misses    = ctr[3];
  assign out_ch.write_misses   = ctr[4];
  assign out_ch.fetch_misses   = ctr[5];

endmodule

// ===== rtl/sacte_chk.sv =====
// ----------------------------------------------------------------------------
// Cache tag engine port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sacte_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] read_accesses,
  input logic [31:0] write_accesses,
  input logic [31:0] fetch_accesses,
  input logic [31:0] read_misses,
  input logic [31:0] write_misses,
  input logic [31:0] fetch_misses
);

  // A stalled result stays offered.
  `SACTE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // Requests are not taken when reset is released, as the tag store clearing begins.
  `SACTE_ASSERT_RESET_EXIT(a_clear_blocks, !in_ready)

  // One request at a time: ready drops after each accepted request.
  `SACTE_ASSERT_NEXT(a_one_inflight, in_valid && in_ready, !in_ready)

  // Misses never outrun accesses of the same kind.
  `SACTE_ASSERT_NOW(a_miss_bound, out_valid,
    read_misses <= read_accesses && write_misses <= write_accesses &&
    fetch_misses <= fetch_accesses)

endmodule

bind set_assoc_cache_tag_engine sacte_chk u_sacte_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .read_accesses  (out_ch.read_accesses),
  .write_accesses (out_ch.write_accesses),
  .fetch_accesses (out_ch.fetch_accesses),
  .read_misses    (out_ch.read_misses),
  .write_misses   (out_ch.write_misses),
  .fetch_misses   (out_ch.fetch_misses)
);

// ===== tb/set_assoc_cache_tag_engine_tb.sv =====
// ----------------------------------------------------------------------------
// Cache tag engine testbench
// Drives read, write and fetch requests through several cache configurations
// and checks every result against a behavioral predictor of the tag engine.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_engine_tb;
  import sacte_pkg::*;

  localparam int LIMIT_CYCLES = 1500000;
  localparam int NLINES = 2 * MAX_SETS * MAX_WAYS;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
  } access_t;

  typedef struct packed {
    logic        hit;
    logic [9:0]  set_index;
    logic [5:0][31:0] ctr;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sacte_in_if  in_ch ();
  sacte_out_if out_ch ();
  sacte_cfg_if cfg_ch ();

  set_assoc_cache_tag_engine uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #6 clk = ~clk;

  // Predictor copy of the engine state.
  logic [7:0]  cache_cfg [8];
  logic [31:0] tag_mem [NLINES];
  logic        val_mem [NLINES];
  logic [31:0] used_mem [NLINES];
  logic [31:0] fill_mem [NLINES];
  int unsigned fill_cnt [2 * MAX_SETS];
  logic [31:0] stamp;
  logic [31:0] counters [6];
  logic [15:0] lfsr;

  access_t  pending_requests [$];
  outcome_t expected_outcomes [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  bit send_pause = 0;
  int cycle_count = 0;
  int n_hits = 0;
  int n_results = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s: got %0h, expected %0h (result %0d)", what, got, want,
             n_results);
    errors++;
  endtask

  function automatic int unsigned ways_eff();
    int unsigned w;
    w = cache_cfg[REG_WAYS];
    if (w < 1) w = 1;
    if (w > MAX_WAYS) w = MAX_WAYS;
    return w;
  endfunction

  function automatic int unsigned sets_lg(input int unsigned raw);
    int unsigned lg;
    lg = raw;
    while (lg > 0 && (1 << lg) > MAX_SETS) lg--;
    return lg;
  endfunction

  function automatic int find_way(input int unsigned base, input int unsigned ways,
                                  input logic [31:0] blk);
    for (int unsigned w = 0; w < ways; w++)
      if (val_mem[base + w] && tag_mem[base + w] == blk) return w;
    return -1;
  endfunction

  function automatic int unsigned choose_victim(input int unsigned base,
                                                input int unsigned ways);
    int unsigned best;
    logic [31:0] a;
    logic [31:0] b;
    best = 0;
    if (cache_cfg[REG_POLICY][1:0] == POL_RAND) begin
      lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
      return lfsr % ways;
    end
    for (int unsigned w = 1; w < ways; w++) begin
      if (cache_cfg[REG_POLICY][1:0] == POL_FIFO) begin
        a = fill_mem[base + w];
        b = fill_mem[base + best];
      end else begin
        a = used_mem[base + w];
        b = used_mem[base + best];
      end
      if (a < b) best = w;
    end
    return best;
  endfunction

  function automatic void place_block(input int unsigned sidx, input int unsigned ways,
                                      input logic [31:0] blk);
    int unsigned base;
    int unsigned slot;
    bit found;
    base = sidx * MAX_WAYS;
    slot = 0;
    found = 0;
    if (fill_cnt[sidx] < ways)
      for (int unsigned w = 0; w < ways; w++)
        if (!found && !val_mem[base + w]) begin
          slot = w;
          found = 1;
        end
    if (found) begin
      if (fill_cnt[sidx] < MAX_WAYS) fill_cnt[sidx]++;
    end else begin
      slot = choose_victim(base, ways);
    end
    tag_mem[base + slot] = blk;
    val_mem[base + slot] = 1'b1;
    used_mem[base + slot] = stamp;
    fill_mem[base + slot] = stamp;
  endfunction

  function automatic void bump(input int k);
    if (counters[k] != 32'hFFFF_FFFF) counters[k]++;
  endfunction

  // Predict the outcome of one access and update the predictor state.
  function automatic outcome_t lookup_access(input access_t acc);
    outcome_t o;
    int unsigned bl, ways, cidx, slg, set_i, sidx, pset;
    int w;
    logic [31:0] blk, pblk, pa;
    o = '0;
    bl = cache_cfg[REG_BLOCK];
    if (bl < BL_MIN) bl = BL_MIN;
    if (bl > BL_MAX) bl = BL_MAX;
    ways = ways_eff();
    if (acc.kind != REQ_NONE) begin
      stamp++;
      bump(acc.kind);
      cidx = (cache_cfg[REG_SPLIT][0] && acc.kind == REQ_FETCH) ? 1 : 0;
      slg = sets_lg(cidx ? cache_cfg[REG_ISETS] : cache_cfg[REG_PSETS]);
      blk = acc.addr >> bl;
      set_i = blk & ((1 << slg) - 1);
      sidx = cidx * MAX_SETS + set_i;
      w = find_way(sidx * MAX_WAYS, ways, blk);
      if (w >= 0) begin
        o.hit = 1'b1;
        used_mem[sidx * MAX_WAYS + w] = stamp;
      end else begin
        bump(3 + acc.kind);
        if (!(acc.kind == REQ_WRITE && !cache_cfg[REG_WALLOC][0])) begin
          place_block(sidx, ways, blk);
          if (cache_cfg[REG_PREFETCH][0]) begin
            pa = acc.addr + (32'd1 << bl);
            pblk = pa >> bl;
            pset = (set_i + 1) & ((1 << slg) - 1);
            if (find_way((cidx * MAX_SETS + pset) * MAX_WAYS, ways, pblk) < 0)
              place_block(cidx * MAX_SETS + pset, ways, pblk);
          end
        end
      end
      o.set_index = set_i[9:0];
    end
    for (int k = 0; k < 6; k++) o.ctr[k] = counters[k];
    return o;
  endfunction

  // Request driver: sends queued accesses and predicts each one as it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_outcomes.push_back(lookup_access(pending_requests.pop_front()));
      end
      if ((!in_ch.valid || in_ch.ready) ) begin
        if (pending_requests.size() > (in_ch.valid && in_ch.ready ? 0 : 0) && !send_pause
            && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.req_type <= pending_requests[0].kind;
          in_ch.address <= pending_requests[0].addr;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random back-pressure plus long hold-off, field checks.
  always @(posedge clk) begin
    outcome_t e;
    cycle_count++;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (expected_outcomes.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          e = expected_outcomes.pop_front();
          if (out_ch.hit) n_hits++;
          if (out_ch.hit !== e.hit) report_mismatch("hit", out_ch.hit, e.hit);
          if (out_ch.set_index !== e.set_index)
            report_mismatch("set_index", out_ch.set_index, e.set_index);
          if (out_ch.read_accesses !== e.ctr[0])
            report_mismatch("read_accesses", out_ch.read_accesses, e.ctr[0]);
          if (out_ch.write_accesses !== e.ctr[1])
            report_mismatch("write_accesses", out_ch.write_accesses, e.ctr[1]);
          if (out_ch.fetch_accesses !== e.ctr[2])
            report_mismatch("fetch_accesses", out_ch.fetch_accesses, e.ctr[2]);
          if (out_ch.read_misses !== e.ctr[3])
            report_mismatch("read_misses", out_ch.read_misses, e.ctr[3]);
          if (out_ch.write_misses !== e.ctr[4])
            report_mismatch("write_misses", out_ch.write_misses, e.ctr[4]);
          if (out_ch.fetch_misses !== e.ctr[5])
            report_mismatch("fetch_misses", out_ch.fetch_misses, e.ctr[5]);
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** set_assoc_cache_tag_engine: FAILED **");
      $finish;
    end
  end

  // Configuration write; the predictor takes it at the handshake.
  task automatic write_reg(input logic [3:0] idx, input logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cache_cfg[idx] = value & ((idx == REG_SPLIT || idx == REG_PREFETCH ||
                               idx == REG_WALLOC) ? 8'h1 :
                              (idx == REG_POLICY) ? 8'h3 : 8'hF);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_requests.size() > 0 || in_ch.valid || expected_outcomes.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Address mostly inside a small window, so that hits and conflicts are frequent.
  function automatic access_t random_access();
    access_t a;
    a.kind = ($urandom_range(39) == 0) ? REQ_NONE : 2'($urandom_range(2));
    case ($urandom_range(9))
      0: a.addr = $urandom();
      1: a.addr = 32'hFFFF_FF00 | 32'($urandom_range(255));
      default: a.addr = (32'($urandom_range(3)) << 28) | 32'($urandom_range(8191));
    endcase
    return a;
  endfunction

  task automatic queue_phase(input int n);
    for (int i = 0; i < n; i++) pending_requests.push_back(random_access());
  endtask

  task automatic apply_settings(input logic [7:0] s [8]);
    drain();
    for (int i = 0; i < 8; i++) write_reg(4'(i), s[i]);
  endtask

  initial begin
    logic [7:0] s [8];
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_READ;
    in_ch.address = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = REG_SPLIT;
    cfg_ch.data = '0;
    cache_cfg = '{8'd0, 8'd4, 8'd1, 8'd6, 8'd6, 8'd0, 8'd0, 8'd1};
    for (int i = 0; i < NLINES; i++) begin
      tag_mem[i] = '0; val_mem[i] = 1'b0; used_mem[i] = '0; fill_mem[i] = '0;
    end
    foreach (fill_cnt[i]) fill_cnt[i] = 0;
    stamp = '0;
    foreach (counters[i]) counters[i] = '0;
    lfsr = LFSR_SEED;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 34;
    recv_idle_pct = 47;

    // Directed part under reset settings: field extremes, all kinds, unknown kind.
    pending_requests.push_back('{REQ_READ, 32'h0});
    pending_requests.push_back('{REQ_READ, 32'h0});
    pending_requests.push_back('{REQ_WRITE, 32'hFFFF_FFFF});
    pending_requests.push_back('{REQ_FETCH, 32'hFFFF_FFF0});
    pending_requests.push_back('{REQ_NONE, 32'hAAAA_5555});
    pending_requests.push_back('{REQ_FETCH, 32'h5555_AAAA});
    pending_requests.push_back('{REQ_WRITE, 32'h0000_0400});
    pending_requests.push_back('{REQ_READ, 32'h0000_0400});

    // Small split cache, random victims, prefetch with address wrap, no allocate.
    s = '{8'd1, 8'd8, 8'd2, 8'd0, 8'd1, POL_RAND, 8'd1, 8'd0};
    apply_settings(s);
    pending_requests.push_back('{REQ_FETCH, 32'hFFFF_FF00});
    pending_requests.push_back('{REQ_WRITE, 32'h1234_5600});
    pending_requests.push_back('{REQ_READ, 32'h1234_5600});
    for (int i = 0; i < 10; i++) pending_requests.push_back('{REQ_READ, 32'(i) << 8});
    queue_phase(300);

    // Full ways, LRU, largest set count, out-of-range register values.
    s = '{8'd0, 8'd15, 8'd15, 8'd15, 8'd10, POL_LRU, 8'd1, 8'd1};
    apply_settings(s);
    queue_phase(300);

    // FIFO with a few sets; then shrink ways to test a stale fill count.
    s = '{8'd1, 8'd4, 8'd8, 8'd2, 8'd3, POL_FIFO, 8'd0, 8'd1};
    apply_settings(s);
    queue_phase(300);
    drain();
    write_reg(REG_WAYS, 8'd0);
    write_reg(REG_POLICY, 8'd3);
    queue_phase(250);

    // Long receiver hold-off while requests keep coming.
    drain();
    send_idle_pct = 47;
    recv_idle_pct = 34;
    write_reg(REG_WAYS, 8'd4);
    write_reg(REG_POLICY, POL_RAND);
    hold_cycles = 400;
    queue_phase(300);

    // Sender pauses until everything has come back.
    while (pending_requests.size() > 150) @(posedge clk);
    send_pause = 1;
    while (in_ch.valid || expected_outcomes.size() > 0) @(posedge clk);
    send_pause = 0;

    s = '{8'd0, 8'd5, 8'd3, 8'd4, 8'd0, POL_LRU, 8'd0, 8'd0};
    apply_settings(s);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_phase(480);
    drain();

    $display("covered %0d results (%0d hits) over unified/split, all policies,",
             n_results, n_hits);
    $display("prefetch and allocate settings, stalls and long back-pressure");
    if (errors == 0 && expected_outcomes.size() == 0) begin
      $display("** set_assoc_cache_tag_engine: PASSED **");
    end else begin
      $display("** set_assoc_cache_tag_engine: FAILED **");
    end
    $finish;
  end

endmodule
